[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[design/rtte_pkg.sv]
// Package for the radar threat evaluator: result codes, CORDIC constants.
// Depends on nothing.
`default_nettype none
package rtte_pkg;
	typedef enum logic [1:0] {
		RK_EVAL = 2'd0,
		RK_DROP = 2'd1,
		RK_OVFL = 2'd2,
		RK_NOTE = 2'd3
	} rkind_t;

	localparam logic [1:0] FC_NONE  = 2'd0;
	localparam logic [1:0] FC_NEAR  = 2'd1;
	localparam logic [1:0] FC_FAULT = 2'd2;

	localparam int ZW = 20;   // angle width
	localparam int XW = 36;   // CORDIC vector width
	localparam logic signed [ZW-1:0] PI_Q16   = 20'sd205887;
	localparam logic signed [ZW-1:0] PI_H_Q16 = 20'sd102944;
	localparam logic [15:0] CORDIC_GAIN = 16'd39797;
	localparam logic [15:0] MIN_TENTH = 16'd26;

	// arctan(2^-i) in 2^-16 rad
	function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
		logic signed [ZW-1:0] r;
		unique case (i)
			4'd0: r = 20'sd51472;
			4'd1: r = 20'sd30386;
			4'd2: r = 20'sd16055;
			4'd3: r = 20'sd8150;
			4'd4: r = 20'sd4091;
			4'd5: r = 20'sd2047;
			4'd6: r = 20'sd1024;
			4'd7: r = 20'sd512;
			4'd8: r = 20'sd256;
			4'd9: r = 20'sd128;
			4'd10: r = 20'sd64;
			4'd11: r = 20'sd32;
			4'd12: r = 20'sd16;
			4'd13: r = 20'sd8;
			4'd14: r = 20'sd4;
			default: r = 20'sd2;
		endcase
		return r;
	endfunction

	// datapath request and done status between sequencer and math unit
	typedef struct packed {
		logic        start;
		logic [15:0] range_dist;
		logic [15:0] rate_c;
		logic signed [15:0] bearing;
		logic [11:0] tsec;
	} rtte_req_t;

	typedef struct packed {
		logic               done;
		logic signed [16:0] x_ahead;
		logic signed [16:0] y_left;
		logic [14:0]        threat;
	} rtte_res_t;
endpackage
`default_nettype wire

[design/rtte_math.sv]
// Shared iterative unit: 16-step CORDIC rotation and a restoring divider.
// Depends on rtte_pkg.
`default_nettype none
module rtte_math (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rtte_pkg::rtte_req_t req,
	output rtte_pkg::rtte_res_t    res
);
	import rtte_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_RUN, S_FIN} st_t;
	st_t st_q;
	logic [4:0] cnt_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic neg_q;
	logic [27:0] num_q;   // dividend shifting out
	logic [16:0] rem_q;
	logic [27:0] quo_q;
	logic [15:0] den_q;
	logic [15:0] gain_in_q;
	logic [15:0] range_q;
	logic [15:0] tcap_q;
	logic [11:0] tsec_q;
	logic [15:0] rate_q;

	// one CORDIC step
	logic signed [XW-1:0] dx, dy;
	logic signed [ZW-1:0] at;
	assign dx = y_q >>> cnt_q[3:0];
	assign dy = x_q >>> cnt_q[3:0];
	assign at = atan_lut(cnt_q[3:0]);

	// one divider step (two quotient bits per cycle)
	logic [16:0] r1, r2, t1, t2;
	logic q1, q2;
	always_comb begin
		t1 = {rem_q[15:0], num_q[27]};
		q1 = t1 >= {1'b0, den_q};
		r1 = q1 ? t1 - {1'b0, den_q} : t1;
		t2 = {r1[15:0], num_q[26]};
		q2 = t2 >= {1'b0, den_q};
		r2 = q2 ? t2 - {1'b0, den_q} : t2;
	end

	// rounding and saturation
	function automatic logic signed [16:0] rsat(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = (v + XW'(32768)) >>> 16;
		if (r > XW'(65535)) return 17'sd65535;
		if (r < -XW'(65535)) return -17'sd65535;
		return r[16:0];
	endfunction

	logic signed [XW-1:0] xf, yf;
	logic [27:0] tq;
	assign xf = neg_q ? -x_q : x_q;
	assign yf = neg_q ? -y_q : y_q;
	assign tq = (quo_q > {12'd0, tcap_q}) ? {12'd0, tcap_q} : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			res.done <= 1'b0;
		end else begin
			res.done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (req.start) begin
					gain_in_q <= req.range_dist;
					range_q <= req.range_dist;
					tsec_q <= req.tsec;
					rate_q <= req.rate_c;
					z_q <= ZW'(req.bearing) <<< 3;
					st_q <= S_MUL;
				end
				S_MUL: begin
					x_q <= XW'({16'd0, gain_in_q} * {16'd0, CORDIC_GAIN});
					y_q <= '0;
					neg_q <= 1'b0;
					if (z_q > PI_H_Q16) begin
						z_q <= z_q - PI_Q16; neg_q <= 1'b1;
					end else if (z_q < -PI_H_Q16) begin
						z_q <= z_q + PI_Q16; neg_q <= 1'b1;
					end
					num_q <= 28'(tsec_q) * 28'(rate_q);
					den_q <= (range_q < MIN_TENTH) ? MIN_TENTH : range_q;
					tcap_q <= 16'(tsec_q) * 16'd10;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
					st_q <= S_RUN;
				end
				S_RUN: begin
					if (z_q >= 0) begin
						x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
					end
					if (cnt_q < 5'd14) begin
						rem_q <= r2;
						quo_q <= {quo_q[25:0], q1, q2};
						num_q <= {num_q[25:0], 2'b00};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) st_q <= S_FIN;
				end
				default: begin
					res.x_ahead <= rsat(xf);
					res.y_left <= rsat(-yf);
					res.threat <= (tq > 28'd32767) ? 15'h7FFF : tq[14:0];
					res.done <= 1'b1;
					st_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[design/radar_target_threat_evaluator_unit.sv]
// Top level of the radar threat evaluator: stream ports, report sequencer.
// Depends on rtte_pkg and rtte_math.
//
//  channel  | dir | contents
//  s_axis   | in  | target field or notice
//  m_axis   | out | one result per request
//  cfg      | in  | threat_seconds register
//
// An evaluated target's result becomes valid after setup, the 16 CORDIC steps
// that also run the two-bit-per-cycle divider, the result state and the done
// flag; other requests are answered in the cycle after they are taken. The next
// request is taken the cycle after the result leaves, so only one request is in
// work at a time. Output register: s_axis_tready falls while a request is in
// work or a result waits. Reset clears all report state.
`default_nettype none
module radar_target_threat_evaluator_unit #(
	parameter int MAX_TARGETS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: target_id[7:0], range_dist[23:8], closing_rate[39:24], bearing[55:40]
	input  wire logic [55:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	input  wire logic        s_axis_tuser,   // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: x_ahead[16:0], y_left[33:17], rate_out[49:34], threat_level[64:50],
	// target_stop[65], fault_code[67:66], count_so_far[72:68], report_stop[73],
	// report_ok[74], pad
	output logic [79:0]      m_axis_tdata,
	output logic             m_axis_tlast,   // end_of_report
	output logic [1:0]       m_axis_tuser,   // result_kind
	input  wire logic        cfg_we,
	input  wire logic [11:0] cfg_wdata
);
	import rtte_pkg::*;

	logic [11:0] tsec_q;
	logic [6:0] count_q;   // wide enough for up to 127 targets
	logic stop_acc_q, ovf_q, valid_q, open_q, busy_q;
	logic [15:0] rate_hold_q;
	logic last_hold_q;
	rtte_req_t req;
	rtte_res_t res;

	assign s_axis_tready = !busy_q && !m_axis_tvalid;
	wire acc = s_axis_tvalid && s_axis_tready;
	wire [7:0] tid = s_axis_tdata[7:0];
	wire [15:0] rng = s_axis_tdata[23:8];
	wire signed [15:0] rate = s_axis_tdata[39:24];

	// start-of-report view of state
	logic [6:0] cnt_e;
	logic ovf_e, sacc_e;
	always_comb begin
		cnt_e = open_q ? count_q : 7'd0;
		ovf_e = open_q ? ovf_q : 1'b0;
		sacc_e = open_q ? stop_acc_q : 1'b0;
	end
	wire eval = acc && !s_axis_tuser && !ovf_e && tid != 8'd0
		&& 32'(cnt_e) < MAX_TARGETS;

	always_comb begin
		req.start = eval;
		req.range_dist = rng;
		req.rate_c = (rate >= $signed(MIN_TENTH)) ? rate : MIN_TENTH;
		req.bearing = s_axis_tdata[55:40];
		req.tsec = tsec_q;
	end

	rtte_math u_math (.clk(clk), .arst_n(arst_n), .req(req), .res(res));

	wire tstop = res.threat >= 15'd256;
	wire [6:0] cnt_n = count_q + 7'd1;

	// report sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsec_q <= 12'd1024;
			count_q <= '0; stop_acc_q <= 0; ovf_q <= 0; valid_q <= 0;
			open_q <= 0; busy_q <= 0; m_axis_tvalid <= 0;
			m_axis_tdata <= '0; m_axis_tlast <= 0; m_axis_tuser <= RK_EVAL;
			rate_hold_q <= '0; last_hold_q <= 0;
		end else begin
			if (cfg_we) tsec_q <= cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			if (acc) begin
				if (s_axis_tuser) begin
					valid_q <= 1'b0;
					m_axis_tvalid <= 1'b1;
					m_axis_tuser <= RK_NOTE;
					m_axis_tlast <= 1'b0;
					m_axis_tdata <= {5'd0, 1'b0, stop_acc_q, count_q[4:0], FC_NONE, 66'd0};
				end else if (eval) begin
					count_q <= cnt_e; stop_acc_q <= sacc_e; ovf_q <= 1'b0;
					open_q <= 1'b1;
					busy_q <= 1'b1;
					rate_hold_q <= rate;
					last_hold_q <= s_axis_tlast;
				end else begin
					logic ov;
					logic vn;
					ov = !ovf_e && tid != 8'd0;
					vn = s_axis_tlast ? !(ovf_e || ov) : (ov ? 1'b0 : valid_q);
					count_q <= cnt_e; stop_acc_q <= sacc_e;
					ovf_q <= ovf_e || ov;
					open_q <= !s_axis_tlast;
					valid_q <= vn;
					m_axis_tvalid <= 1'b1;
					m_axis_tuser <= (ovf_e || ov) ? RK_OVFL : RK_DROP;
					m_axis_tlast <= s_axis_tlast;
					m_axis_tdata <= {5'd0, s_axis_tlast & vn, sacc_e, cnt_e[4:0],
						ov ? FC_FAULT : FC_NONE, 66'd0};
				end
			end
			if (res.done) begin
				count_q <= cnt_n;
				stop_acc_q <= stop_acc_q | tstop;
				busy_q <= 1'b0;
				if (last_hold_q) begin
					open_q <= 1'b0;
					valid_q <= 1'b1;
				end
				m_axis_tvalid <= 1'b1;
				m_axis_tuser <= RK_EVAL;
				m_axis_tlast <= last_hold_q;
				m_axis_tdata <= {5'd0, last_hold_q, stop_acc_q | tstop, cnt_n[4:0],
					tstop ? FC_NEAR : FC_NONE, tstop, res.threat,
					rate_hold_q, res.y_left, res.x_ahead};
			end
		end
	end
endmodule
`default_nettype wire

[design/rtte_checker.sv]
// Port-level checker for the radar threat evaluator, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rtte_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [79:0] m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic [1:0]  m_axis_tuser
);
	// no intake while a result waits
	`ASSERT_IMPL(a_no_overlap, clk, arst_n, !(m_axis_tvalid && s_axis_tready))
	// report_ok only on the last field
	`ASSERT_IMPL(a_ok_last, clk, arst_n, !m_axis_tvalid || m_axis_tlast || !m_axis_tdata[74])
	// fault code never 3
	`ASSERT_IMPL(a_fault, clk, arst_n, !m_axis_tvalid || m_axis_tdata[67:66] != 2'd3)
	// stalled result holds
	`ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
endmodule

bind radar_target_threat_evaluator_unit rtte_checker u_chk (.*);
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the radar target threat evaluator: a scoreboard class predicts every result
// from the accepted requests, with random idling, a long output stall and threat settings.
// Depends on rtte_pkg and radar_target_threat_evaluator_unit.
`default_nettype none
module tb_top;
	import rtte_pkg::*;

	localparam int MAXT = 16;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic signed [15:0] rate;
		logic [14:0]        thr;
		logic               stop;
		logic [1:0]         fault;
		logic [4:0]         cnt;
		logic               rstop;
		logic               ok;
		logic               eor;
	} threat_res_t;

	int errors = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
	endtask

	// round and clamp a CORDIC coordinate
	function automatic longint rnd_sat(input longint v);
		longint r;
		r = (v + 32768) >>> 16;
		if (r > 65535) r = 65535;
		if (r < -65535) r = -65535;
		return r;
	endfunction

	class threat_board;
		logic [11:0] tsec;
		int cnt;
		bit acc, ovf, vld, open;
		threat_res_t pending[$];

		function void clear();
			tsec = 12'd1024;
			cnt = 0; acc = 0; ovf = 0; vld = 0; open = 0;
		endfunction

		function void polar(input int rng, input int brg, output longint xo, output longint yo);
			longint z, x, y, dx, dy;
			bit neg;
			z = longint'(brg) * 8;
			x = longint'(rng) * 39797;
			y = 0;
			neg = 0;
			if (z > PI_H_Q16) begin z -= PI_Q16; neg = 1; end
			else if (z < -PI_H_Q16) begin z += PI_Q16; neg = 1; end
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin x -= dx; y += dy; z -= atan_lut(4'(i)); end
				else begin x += dx; y -= dy; z += atan_lut(4'(i)); end
			end
			if (neg) begin x = -x; y = -y; end
			xo = rnd_sat(x);
			yo = rnd_sat(-y);
		endfunction

		// note an accepted request and queue its expected result
		function void note_request(input bit kind, input logic [7:0] tid, input logic [15:0] rng,
				input logic signed [15:0] rate, input logic signed [15:0] brg, input bit last);
			threat_res_t e;
			longint xo, yo, rf, c, t;
			e = '0;
			if (kind) begin
				vld = 0;
				e.kind = RK_NOTE;
			end else begin
				if (!open) begin cnt = 0; acc = 0; ovf = 0; open = 1; end
				if (ovf) e.kind = RK_OVFL;
				else if (tid == 0) e.kind = RK_DROP;
				else if (cnt >= MAXT) begin
					ovf = 1; vld = 0; e.fault = FC_FAULT; e.kind = RK_OVFL;
				end else begin
					rf = (rng < 26) ? 26 : rng;
					c = (rate >= 26) ? rate : 26;
					t = (longint'(tsec) * c) / rf;
					if (t > longint'(tsec) * 10) t = longint'(tsec) * 10;
					if (t > 32767) t = 32767;
					polar(int'(rng), int'(brg), xo, yo);
					e.x = 17'(xo); e.y = 17'(yo); e.rate = rate; e.thr = 15'(t);
					e.stop = (t >= 256);
					e.fault = e.stop ? FC_NEAR : FC_NONE;
					if (e.stop) acc = 1;
					cnt++;
					e.kind = RK_EVAL;
				end
				if (last) begin
					open = 0;
					if (!ovf) vld = 1;
					e.eor = 1;
					e.ok = vld;
				end
			end
			e.cnt = 5'(cnt);
			e.rstop = acc;
			pending.push_back(e);
		endfunction

		task check_result(input threat_res_t g);
			threat_res_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", g.kind, -1);
				return;
			end
			w = pending.pop_front();
			if (g.kind !== w.kind) report_mismatch("result_kind", g.kind, w.kind);
			if (g.x !== w.x) report_mismatch("x_ahead", g.x, w.x);
			if (g.y !== w.y) report_mismatch("y_left", g.y, w.y);
			if (g.rate !== w.rate) report_mismatch("rate_out", g.rate, w.rate);
			if (g.thr !== w.thr) report_mismatch("threat_level", g.thr, w.thr);
			if (g.stop !== w.stop) report_mismatch("target_stop", g.stop, w.stop);
			if (g.fault !== w.fault) report_mismatch("fault_code", g.fault, w.fault);
			if (g.cnt !== w.cnt) report_mismatch("count_so_far", g.cnt, w.cnt);
			if (g.rstop !== w.rstop) report_mismatch("report_stop", g.rstop, w.rstop);
			if (g.ok !== w.ok) report_mismatch("report_ok", g.ok, w.ok);
			if (g.eor !== w.eor) report_mismatch("end_of_report", g.eor, w.eor);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tlast = 0, s_axis_tuser = 0;
	logic [55:0] s_axis_tdata = '0;
	logic s_axis_tready;
	logic m_axis_tvalid, m_axis_tlast;
	logic m_axis_tready = 0;
	logic [79:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_we = 0;
	logic [11:0] cfg_wdata = '0;

	threat_board board = new();
	bit quiet = 0;       // no idling near the end
	bit hold_off = 0;    // long output stall
	int cycles = 0;
	int sent = 0;
	int got = 0;

	always #4 clk = ~clk;

	radar_target_threat_evaluator_unit #(.MAX_TARGETS(MAXT)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("radar_target_threat_evaluator_unit: mismatch");
			$finish;
		end
	end

	// result side: check accepted results, random ready bursts
	always @(posedge clk) begin
		threat_res_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			r.kind = m_axis_tuser;
			r.x = m_axis_tdata[16:0];
			r.y = m_axis_tdata[33:17];
			r.rate = m_axis_tdata[49:34];
			r.thr = m_axis_tdata[64:50];
			r.stop = m_axis_tdata[65];
			r.fault = m_axis_tdata[67:66];
			r.cnt = m_axis_tdata[72:68];
			r.rstop = m_axis_tdata[73];
			r.ok = m_axis_tdata[74];
			r.eor = m_axis_tlast;
			board.check_result(r);
			got++;
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_axis_tready <= 0;
				@(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				n = $urandom_range(1, 15);
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				n = $urandom_range(1, 20);
				repeat (n) begin
					@(posedge clk);
					if (hold_off) break;
				end
			end
		end
	end

	// offer one request and wait for its acceptance; valid stays up for the next one
	task automatic send_field(input bit kind, input logic [7:0] tid, input logic [15:0] rng,
			input logic [15:0] rate, input logic [15:0] brg, input bit last);
		int n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			n = $urandom_range(1, 15);
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= kind;
		s_axis_tlast <= last;
		s_axis_tdata <= {brg, rate, rng, tid};
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(kind, tid, rng, rate, brg, last);
		sent++;
	endtask

	// random target with biased special values
	task automatic send_random(input bit last);
		logic [7:0] tid;
		logic [15:0] rng, rate, brg;
		tid = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		case ($urandom_range(0, 3))
			0: rng = 16'($urandom_range(0, 40));
			1: rng = 16'($urandom_range(0, 2000));
			default: rng = 16'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: rate = 16'($urandom_range(0, 60));
			1: rate = 16'($urandom_range(0, 8000));
			default: rate = 16'($urandom);
		endcase
		brg = 16'($urandom);
		send_field(($urandom_range(0, 24) == 0), tid, rng, rate, brg, last);
	endtask

	task automatic drain_and_write(input logic [11:0] v);
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		board.tsec = v;
	endtask

	initial begin
		int len;
		board.clear();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, drop, notice, near and far targets
		send_field(0, 8'd1, 16'd0, 16'sh7FFF, 16'sh7FFF, 0);
		send_field(0, 8'd255, 16'hFFFF, 16'sh8000, 16'sh8000, 0);
		send_field(0, 8'd0, 16'd100, 16'd100, 16'd0, 0);
		send_field(0, 8'd7, 16'd25, 16'd25, 16'd0, 0);
		send_field(0, 8'd8, 16'd26, 16'd26, 16'sd12868, 0);
		send_field(0, 8'd9, 16'd2560, 16'd256, -16'sd12868, 0);
		send_field(1, 8'd0, 16'd0, 16'd0, 16'd0, 0);
		send_field(0, 8'd10, 16'd5000, 16'hFFF0, 16'sd25000, 1);
		send_field(1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
		// overflow report: 18 targets
		for (int i = 0; i < 18; i++)
			send_field(0, 8'(i + 1), 16'd1000, 16'd500, 16'(i * 3000), i == 17);
		drain_and_write(12'd256);
		send_field(0, 8'd3, 16'd512, 16'd512, 16'd0, 1);
		drain_and_write(12'd2560);
		send_field(0, 8'd3, 16'd10, 16'd32767, 16'd0, 1);
		drain_and_write(12'hFFF);
		send_field(0, 8'd4, 16'd1, 16'd32767, 16'd100, 1);

		// random reports, with a few setting changes
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 1) begin
				fork
					begin
						hold_off = 1;
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			if (ph == 3) quiet = 1;
			while (sent < 40 + (ph + 1) * 155) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
				for (int k = 0; k < len; k++) send_random(k == len - 1 || $urandom_range(0, 30) == 0);
			end
			drain_and_write(ph == 0 ? 12'd256 : 12'($urandom_range(256, 2560)));
		end

		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Ran %0d requests, %0d results: targets, drops, notices, overflow, stall.",
			sent, got);
		if (errors == 0 && board.pending.size() == 0)
			$display("radar_target_threat_evaluator_unit: match");
		else
			$display("radar_target_threat_evaluator_unit: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
